/* design/brp_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the HTTP byte-range parser.
// No dependencies; every other file of the block refers to it by scoped names.

package brp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ABSENT = 2'd0,
        ST_SAT    = 2'd1,
        ST_UNSAT  = 2'd2
    } t_status;

    // One input beat: a header byte, its last flag and the object size.
    typedef struct packed {
        logic [7:0]  header_byte;
        logic        last_byte;
        logic [63:0] object_size;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        t_status     status;
        logic [63:0] range_offset;
        logic [63:0] range_length;
    } t_out_beat;

    // Summary of a whole header, handed from the scanner to the evaluator.
    typedef struct packed {
        logic        hdr_ok;       // prefix matched, dash seen, no comma
        logic        start_empty;
        logic        start_ok;
        logic [63:0] start_value;
        logic        end_empty;
        logic        end_ok;
        logic [63:0] end_value;
    } t_scan;

    localparam logic [2:0] PREFIX_LEN = 3'd6;
    localparam logic [4:0] DIGIT_SAT  = 5'd20;
    localparam logic [4:0] MAX_DIGITS = 5'd19;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Expected byte of the unit prefix "bytes=" at a given position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h62; // b
            3'd1:    c = 8'h79; // y
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h73; // s
            3'd5:    c = 8'h3D; // =
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* design/brp_scan.sv */
`timescale 1ns / 1ps
// Per-byte header scanner: prefix match, dash split and decimal accumulation.
// Depends on brp_pkg.

module brp_scan (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output brp_pkg::t_scan  o_snap
);

    logic [2:0]  r_pos,       n_pos;
    logic        r_failed,    n_failed;
    logic        r_comma,     n_comma;
    logic        r_dash,      n_dash;
    logic [63:0] r_start,     n_start;
    logic [4:0]  r_start_dig, n_start_dig;
    logic        r_start_bad, n_start_bad;
    logic [63:0] r_end,       n_end;
    logic [4:0]  r_end_dig,   n_end_dig;
    logic        r_end_bad,   n_end_bad;

    logic        w_is_digit;
    logic [63:0] w_digit;

    assign w_is_digit = (i_byte >= brp_pkg::CHAR_ZERO) && (i_byte <= brp_pkg::CHAR_NINE);
    assign w_digit    = {60'd0, i_byte[3:0]};

    always_comb begin
        n_pos       = r_pos;
        n_failed    = r_failed;
        n_comma     = r_comma;
        n_dash      = r_dash;
        n_start     = r_start;
        n_start_dig = r_start_dig;
        n_start_bad = r_start_bad;
        n_end       = r_end;
        n_end_dig   = r_end_dig;
        n_end_bad   = r_end_bad;
        if (r_failed) begin
            // Everything after a prefix mismatch is ignored.
        end else if (r_pos < brp_pkg::PREFIX_LEN) begin
            if (i_byte == brp_pkg::prefix_char(r_pos)) begin
                n_pos = r_pos + 3'd1;
            end else begin
                n_failed = 1'b1;
            end
        end else begin
            if (i_byte == brp_pkg::CHAR_COMMA) begin
                n_comma = 1'b1;
            end
            if (!r_dash && (i_byte == brp_pkg::CHAR_DASH)) begin
                n_dash = 1'b1;
            end else if (r_dash) begin
                if (r_end_dig != brp_pkg::DIGIT_SAT) begin
                    n_end_dig = r_end_dig + 5'd1;
                end
                if (w_is_digit) begin
                    n_end = (r_end << 3) + (r_end << 1) + w_digit;
                end else begin
                    n_end_bad = 1'b1;
                end
            end else begin
                if (r_start_dig != brp_pkg::DIGIT_SAT) begin
                    n_start_dig = r_start_dig + 5'd1;
                end
                if (w_is_digit) begin
                    n_start = (r_start << 3) + (r_start << 1) + w_digit;
                end else begin
                    n_start_bad = 1'b1;
                end
            end
        end
    end

    // The summary reflects the header including the byte being taken now.
    always_comb begin
        o_snap.hdr_ok      = !n_failed && (n_pos == brp_pkg::PREFIX_LEN) && !n_comma && n_dash;
        o_snap.start_empty = (n_start_dig == 5'd0);
        o_snap.start_ok    = (n_start_dig != 5'd0) && (n_start_dig <= brp_pkg::MAX_DIGITS)
                             && !n_start_bad;
        o_snap.start_value = n_start;
        o_snap.end_empty   = (n_end_dig == 5'd0);
        o_snap.end_ok      = (n_end_dig != 5'd0) && (n_end_dig <= brp_pkg::MAX_DIGITS)
                             && !n_end_bad;
        o_snap.end_value   = n_end;
    end

    // State clears after the last byte so the next header starts fresh.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos       <= '0;
            r_failed    <= 1'b0;
            r_comma     <= 1'b0;
            r_dash      <= 1'b0;
            r_start     <= '0;
            r_start_dig <= '0;
            r_start_bad <= 1'b0;
            r_end       <= '0;
            r_end_dig   <= '0;
            r_end_bad   <= 1'b0;
        end else if (i_en) begin
            r_pos       <= n_pos;
            r_failed    <= n_failed;
            r_comma     <= n_comma;
            r_dash      <= n_dash;
            r_start     <= n_start;
            r_start_dig <= n_start_dig;
            r_start_bad <= n_start_bad;
            r_end       <= n_end;
            r_end_dig   <= n_end_dig;
            r_end_bad   <= n_end_bad;
        end
    end

endmodule

/* design/brp_eval.sv */
`timescale 1ns / 1ps
// Two-stage range evaluator: status and bounds, then offset and length.
// Depends on brp_pkg; the second stage is the block's output register.

module brp_eval (
    input  logic               i_clk,
    input  logic               i_ld1,
    input  logic               i_ld2,
    input  brp_pkg::t_scan     i_snap,
    input  logic [63:0]        i_size,
    output brp_pkg::t_out_beat o_data
);

    brp_pkg::t_status r_st, n_st;
    logic             r_sfx, n_sfx;
    logic [63:0]      r_a, n_a;
    logic [63:0]      r_b, n_b;
    brp_pkg::t_out_beat r_out, n_out;

    logic [63:0] w_size_m1;
    logic        w_end_lt_last;
    logic [63:0] w_diff;

    assign w_size_m1     = i_size - 64'd1;
    assign w_end_lt_last = ({1'b0, i_snap.end_value} + 65'd1) < {1'b0, i_size};

    // Stage one: decide everything except the final end-below-start check.
    // For a suffix range a is the size and b the clamped count; for an
    // explicit range a is the clamped last byte and b the start.
    always_comb begin
        n_st  = brp_pkg::ST_ABSENT;
        n_sfx = i_snap.start_empty;
        n_a   = i_size;
        n_b   = '0;
        if (i_snap.hdr_ok && !(i_snap.start_empty && i_snap.end_empty)) begin
            if (i_snap.start_empty) begin
                if (i_snap.end_ok) begin
                    if (i_snap.end_value == 64'd0) begin
                        n_st = brp_pkg::ST_UNSAT;
                    end else begin
                        n_b  = (i_snap.end_value < i_size) ? i_snap.end_value : i_size;
                        n_st = (i_size == 64'd0) ? brp_pkg::ST_UNSAT : brp_pkg::ST_SAT;
                    end
                end
            end else if (i_snap.start_ok) begin
                if (i_snap.start_value >= i_size) begin
                    n_st = brp_pkg::ST_UNSAT;
                end else if (!i_snap.end_empty && !i_snap.end_ok) begin
                    n_st = brp_pkg::ST_ABSENT;
                end else begin
                    n_st = brp_pkg::ST_SAT;
                    n_b  = i_snap.start_value;
                    n_a  = (!i_snap.end_empty && w_end_lt_last) ? i_snap.end_value
                                                                 : w_size_m1;
                end
            end
        end
    end

    assign w_diff = r_a - r_b;

    always_comb begin
        n_out.status       = r_st;
        n_out.range_offset = '0;
        n_out.range_length = '0;
        if (r_st == brp_pkg::ST_SAT) begin
            if (r_sfx) begin
                n_out.range_offset = w_diff;
                n_out.range_length = r_b;
            end else if (r_a < r_b) begin
                n_out.status = brp_pkg::ST_UNSAT;
            end else begin
                n_out.range_offset = r_b;
                n_out.range_length = w_diff + 64'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld1) begin
            r_st  <= n_st;
            r_sfx <= n_sfx;
            r_a   <= n_a;
            r_b   <= n_b;
        end
        if (i_ld2) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

/* design/http_byte_range_parser_top.sv */
`timescale 1ns / 1ps
// Top level of the HTTP single byte-range parser.
// Depends on brp_pkg, brp_scan and brp_eval.
//
//  Channel  Direction  Handshake          Payload
//  input    in         i_valid / o_ready  i_data  (brp_pkg::t_in_beat)
//  output   out        o_valid / i_ready  o_data  (brp_pkg::t_out_beat)
//
// The block takes one header byte per cycle unless a last byte is held waiting.
// Each beat is first captured in an input register, from which the scanner consumes it.
// A beat flagged last produces one result, which passes the input register, the
// evaluation register and the output register before it appears on o_valid.
// Reset is synchronous and active low; it clears the parser state and all
// valid flags. When the output stalls, non-last bytes keep streaming into the
// scanner; only a last byte waits for room in the evaluation stages.

module http_byte_range_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  brp_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output brp_pkg::t_out_beat o_data
);

    // Input register.
    brp_pkg::t_in_beat r_in;
    logic              r_in_v;
    logic              r_e1_v;
    logic              r_out_v;

    logic           w_out_free;
    logic           w_ld1;
    logic           w_ld2;
    logic           w_e1_free;
    logic           w_take;
    logic           w_in_acc;
    brp_pkg::t_scan w_snap;

    // Stall chain from the output back toward the input. A result moves into
    // the output register when that is empty or being drained; the evaluation
    // register is free when empty or moving on.
    assign w_out_free = !r_out_v || i_ready;
    assign w_ld2      = r_e1_v && w_out_free;
    assign w_e1_free  = !r_e1_v || w_ld2;

    // The scanner consumes the held byte unless it is a last byte that has
    // nowhere to put its summary yet.
    assign w_take   = r_in_v && (!r_in.last_byte || w_e1_free);
    assign w_ld1    = r_in_v && r_in.last_byte && w_e1_free;
    assign o_ready  = !r_in_v || w_take;
    assign w_in_acc = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_e1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_in_v  <= w_in_acc || (r_in_v && !w_take);
            r_e1_v  <= w_ld1 || (r_e1_v && !w_ld2);
            r_out_v <= w_ld2 || (r_out_v && !i_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_data;
        end
    end

    brp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_take),
        .i_byte  (r_in.header_byte),
        .i_last  (r_in.last_byte),
        .o_snap  (w_snap)
    );

    // The object size is sampled together with the last byte's summary.
    brp_eval u_eval (
        .i_clk  (i_clk),
        .i_ld1  (w_ld1),
        .i_ld2  (w_ld2),
        .i_snap (w_snap),
        .i_size (r_in.object_size),
        .o_data (o_data)
    );

    assign o_valid = r_out_v;

    // Offset and length carry meaning only for a satisfiable range.
    a_zero_unless_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status != brp_pkg::ST_SAT)) |->
        ((o_data.range_offset == 64'd0) && (o_data.range_length == 64'd0)))
        else $error("non-satisfiable result carries a range");

    // A satisfiable range is never empty.
    a_sat_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == brp_pkg::ST_SAT)) |-> (o_data.range_length != 64'd0))
        else $error("satisfiable result with zero length");

    // A new result only arrives from a filled evaluation register.
    a_out_from_e1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_v) |-> $past(r_e1_v))
        else $error("result appeared without an evaluated header");

    // Only a last byte loads the evaluation stage.
    a_ld1_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ld1 |-> (w_take && r_in.last_byte))
        else $error("evaluation loaded without a consumed last byte");

endmodule
